// File: src/peer_allowed_prefix_match_core_defines.svh
// ---------------------------------------------------------------------------
// peer allowed prefix match core: assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while in reset
// ---------------------------------------------------------------------------
`ifndef PEER_ALLOWED_PREFIX_MATCH_CORE_DEFINES_SVH
`define PEER_ALLOWED_PREFIX_MATCH_CORE_DEFINES_SVH

// property that must hold at every edge out of reset
`define PAMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define PAMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pamc_pkg.sv
// ---------------------------------------------------------------------------
// pamc_pkg
// sizes, operation codes and controller/datapath link types
// ---------------------------------------------------------------------------
package pamc_pkg;

  localparam int unsigned MaxPeerCount = 256;
  localparam int unsigned RulesPerPeer = 128;
  localparam int unsigned TotalRules   = 1024;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned PrefixW   = 6;
  localparam int unsigned PeerW     = 8;
  localparam int unsigned OpW       = 2;
  localparam int unsigned RuleIdxW  = (TotalRules > 1) ? $clog2(TotalRules) : 1;
  localparam int unsigned RuleCntW  = $clog2(TotalRules + 1);
  localparam int unsigned PeerCntW  = $clog2(MaxPeerCount + 1);
  localparam int unsigned LastCntW  = $clog2(RulesPerPeer + 1);
  localparam int unsigned RuleW     = AddrW + PrefixW + PeerW;

  localparam logic [PrefixW-1:0] HostPrefix = PrefixW'(32);

  typedef enum logic [OpW-1:0] {
    OP_NEW_PEER  = 2'd0,
    OP_ADD_RULE  = 2'd1,
    OP_ROUTE_OUT = 2'd2,
    OP_CHECK_IN  = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic issue;      // read next rule entry
    logic load_imm;   // result of new_peer / add_rule into output register
    logic load_scan;  // result of a lookup into output register
    logic scan_hit;   // lookup found a matching rule
  } pamc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;  // incoming item needs a table scan
    logic more;       // rule entries left to read
    logic hit;        // registered read data matches the lookup
  } pamc_sts_t;

  // network mask of a prefix length, lengths above 32 give a host mask
  function automatic logic [AddrW-1:0] mask_of(input logic [PrefixW-1:0] len);
    mask_of = ~({AddrW{1'b1}} >> len);
  endfunction

endpackage

// File: src/pamc_req_if.sv
// ---------------------------------------------------------------------------
// pamc_req_if
// request channel: operation item with valid/ready handshake
// ---------------------------------------------------------------------------
interface pamc_req_if;
  logic                         valid;
  logic                         ready;
  logic [pamc_pkg::OpW-1:0]     operation;
  logic [pamc_pkg::AddrW-1:0]   address;
  logic [pamc_pkg::PrefixW-1:0] prefix_len;
  logic [pamc_pkg::PeerW-1:0]   peer_number;

  modport source (output valid, output operation, output address, output prefix_len,
                  output peer_number, input ready);
  modport sink   (input valid, input operation, input address, input prefix_len,
                  input peer_number, output ready);
endinterface

// File: src/pamc_rsp_if.sv
// ---------------------------------------------------------------------------
// pamc_rsp_if
// result channel: one result item per request with valid/ready handshake
// ---------------------------------------------------------------------------
interface pamc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [pamc_pkg::PeerW-1:0] peer_found;

  modport source (output valid, output accepted, output peer_found, input ready);
  modport sink   (input valid, input accepted, input peer_found, output ready);
endinterface

// File: src/peer_allowed_prefix_match_core.sv
// ---------------------------------------------------------------------------
// peer_allowed_prefix_match_core
// ipv4 prefix rule table with peers in definition order, first-match lookup
// ---------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    operation, address, prefix_len, peer_number
//  rsp_o    out  valid/ready    accepted, peer_found
//
//  new_peer and add_rule results sit in the output register in the cycle after
//  the item is taken. route_out and check_in scan the rule ram one entry a cycle,
//  stopping at the first hit or after the last stored rule; nothing is scanned
//  for an empty table or a check_in of an unknown peer.
//  the single read port of the rule ram sets the lookup time.
//  reset clears the counters and controller state; the rule ram is read only below the fill count.
//  a new item is taken while no scan runs and the output register is empty or being drained.
`include "peer_allowed_prefix_match_core_defines.svh"

module peer_allowed_prefix_match_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pamc_req_if.sink  req_i,
  pamc_rsp_if.source rsp_o
);

  pamc_pkg::pamc_cmd_t cmd;
  pamc_pkg::pamc_sts_t sts;

  // controller: handshakes and scan sequencing
  pamc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: rule ram, counters, compare, result register
  pamc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (req_i.operation),
    .address_i     (req_i.address),
    .prefix_len_i  (req_i.prefix_len),
    .peer_number_i (req_i.peer_number),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .accepted_o    (rsp_o.accepted),
    .peer_found_o  (rsp_o.peer_found)
  );

  // an item is only taken when the output register can hold its result
  `PAMC_ASSERT(a_ready_out_free, !req_i.ready || !rsp_o.valid || rsp_o.ready, "item taken over full output")
  // no new item while the rule ram is being scanned
  `PAMC_ASSERT(a_no_take_in_scan, !cmd.issue || !req_i.ready, "item taken during scan")
  // a lookup without a hit never names a peer
  `PAMC_ASSERT_NEXT(a_drop_no_peer, cmd.load_scan && !cmd.scan_hit, rsp_o.peer_found == '0, "drop with peer")

endmodule

// File: src/pamc_ram.sv
// ---------------------------------------------------------------------------
// pamc_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module pamc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pamc_ctrl.sv
// ---------------------------------------------------------------------------
// pamc_ctrl
// handshake and scan sequencing for the rule table
// ---------------------------------------------------------------------------
module pamc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  input  pamc_pkg::pamc_sts_t sts_i,
  output pamc_pkg::pamc_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e state_q;
  logic   rsp_valid_q;
  logic   pend_q;      // read data of the previous cycle is valid
  logic   accept;
  logic   finish;

  assign req_ready_o = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;
  assign finish      = (state_q == S_SCAN) && ((pend_q && sts_i.hit) || (!pend_q && !sts_i.more));

  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = accept;
    cmd_o.load_imm  = accept && !sts_i.is_lookup;
    cmd_o.issue     = (state_q == S_SCAN) && !finish && sts_i.more;
    cmd_o.load_scan = finish;
    cmd_o.scan_hit  = pend_q && sts_i.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          pend_q <= 1'b0;
          if (accept) begin
            if (sts_i.is_lookup) begin
              rsp_valid_q <= 1'b0;
              state_q     <= S_SCAN;
            end else begin
              rsp_valid_q <= 1'b1;
            end
          end else if (rsp_ready_i) begin
            rsp_valid_q <= 1'b0;
          end
        end
        S_SCAN: begin
          pend_q <= cmd_o.issue;
          if (finish) begin
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: src/pamc_dp.sv
// ---------------------------------------------------------------------------
// pamc_dp
// rule table, counters, match compare and result register
// ---------------------------------------------------------------------------
module pamc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [pamc_pkg::OpW-1:0]       operation_i,
  input  logic [pamc_pkg::AddrW-1:0]     address_i,
  input  logic [pamc_pkg::PrefixW-1:0]   prefix_len_i,
  input  logic [pamc_pkg::PeerW-1:0]     peer_number_i,
  input  pamc_pkg::pamc_cmd_t            cmd_i,
  output pamc_pkg::pamc_sts_t            sts_o,
  output logic                           accepted_o,
  output logic [pamc_pkg::PeerW-1:0]     peer_found_o
);

  pamc_pkg::op_e                     op_in;
  pamc_pkg::op_e                     op_q;
  logic [pamc_pkg::AddrW-1:0]        addr_q;
  logic [pamc_pkg::PeerW-1:0]        who_q;
  logic                              who_ok_q;
  logic [pamc_pkg::RuleCntW-1:0]     stored_rules_q;
  logic [pamc_pkg::PeerCntW-1:0]     peer_total_q;
  logic [pamc_pkg::LastCntW-1:0]     rules_last_q;
  logic [pamc_pkg::RuleCntW-1:0]     rd_idx_q;
  logic                              accepted_q;
  logic [pamc_pkg::PeerW-1:0]        peer_found_q;

  logic [pamc_pkg::PrefixW-1:0]      plen_sat;
  logic                              peer_ok;
  logic                              rule_ok;
  logic                              imm_ok;
  logic                              wr_en;
  logic [pamc_pkg::RuleW-1:0]        wr_data;
  logic [pamc_pkg::RuleW-1:0]        rd_data;
  logic [pamc_pkg::AddrW-1:0]        rd_net;
  logic [pamc_pkg::PrefixW-1:0]      rd_prefix;
  logic [pamc_pkg::PeerW-1:0]        rd_owner;

  assign op_in    = pamc_pkg::op_e'(operation_i);
  assign plen_sat = (prefix_len_i > pamc_pkg::HostPrefix) ? pamc_pkg::HostPrefix
                                                           : prefix_len_i;

  assign peer_ok = peer_total_q < pamc_pkg::PeerCntW'(pamc_pkg::MaxPeerCount);
  assign rule_ok = (peer_total_q != '0)
                && (rules_last_q < pamc_pkg::LastCntW'(pamc_pkg::RulesPerPeer))
                && (stored_rules_q < pamc_pkg::RuleCntW'(pamc_pkg::TotalRules));
  assign imm_ok  = (op_in == pamc_pkg::OP_NEW_PEER) ? peer_ok : rule_ok;
  assign wr_en   = cmd_i.accept && (op_in == pamc_pkg::OP_ADD_RULE) && rule_ok;
  assign wr_data = {address_i & pamc_pkg::mask_of(plen_sat), plen_sat,
                    pamc_pkg::PeerW'(peer_total_q - 1'b1)};

  pamc_ram #(
    .Width (pamc_pkg::RuleW),
    .Depth (pamc_pkg::TotalRules)
  ) u_rules (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (stored_rules_q[pamc_pkg::RuleIdxW-1:0]),
    .wdata_i (wr_data),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_idx_q[pamc_pkg::RuleIdxW-1:0]),
    .rdata_o (rd_data)
  );

  assign {rd_net, rd_prefix, rd_owner} = rd_data;

  assign sts_o.is_lookup = (op_in == pamc_pkg::OP_ROUTE_OUT) || (op_in == pamc_pkg::OP_CHECK_IN);
  assign sts_o.more      = (rd_idx_q < stored_rules_q)
                        && ((op_q == pamc_pkg::OP_ROUTE_OUT) || who_ok_q);
  assign sts_o.hit       = ((addr_q & pamc_pkg::mask_of(rd_prefix)) == rd_net)
                        && ((op_q == pamc_pkg::OP_ROUTE_OUT) || (rd_owner == who_q));

  // table counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_rules_q <= '0;
      peer_total_q   <= '0;
      rules_last_q   <= '0;
      rd_idx_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        rd_idx_q <= '0;
        if (op_in == pamc_pkg::OP_NEW_PEER && peer_ok) begin
          peer_total_q <= peer_total_q + 1'b1;
          rules_last_q <= '0;
        end
        if (wr_en) begin
          stored_rules_q <= stored_rules_q + 1'b1;
          rules_last_q   <= rules_last_q + 1'b1;
        end
      end else if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  // item fields and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_in;
      addr_q   <= address_i;
      who_q    <= peer_number_i;
      who_ok_q <= pamc_pkg::PeerCntW'(peer_number_i) < peer_total_q;
    end
    if (cmd_i.load_imm) begin
      accepted_q   <= imm_ok;
      peer_found_q <= '0;
    end else if (cmd_i.load_scan) begin
      accepted_q   <= cmd_i.scan_hit;
      peer_found_q <= (cmd_i.scan_hit && op_q == pamc_pkg::OP_ROUTE_OUT) ? rd_owner : '0;
    end
  end

  assign accepted_o   = accepted_q;
  assign peer_found_o = peer_found_q;

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// tb: peer allowed prefix match core testbench
// a directed table of operations, then random traffic and a fill to the
// per-peer and peer limits; every result is checked against a typed answer or
// a rule table kept in step
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 6;
  localparam int RandomItems  = 160;
  localparam int HoldCycles   = 300;
  localparam int DrainLimit   = 200000;
  localparam int TimeoutNs    = 60_000_000;
  localparam int DirectedRows = 25;

  // one result as the block reports it
  typedef struct packed {
    logic                       accepted;
    logic [pamc_pkg::PeerW-1:0] peer_found;
  } verdict_t;

  // one row of the directed plan, with a typed answer where it is obvious
  typedef struct packed {
    pamc_pkg::op_e                op;
    logic [pamc_pkg::AddrW-1:0]   addr;
    logic [pamc_pkg::PrefixW-1:0] plen;
    logic [pamc_pkg::PeerW-1:0]   peer;
    logic                         typed;
    logic                         want_ok;
    logic [pamc_pkg::PeerW-1:0]   want_peer;
  } plan_row_t;

  localparam plan_row_t DirectedPlan [DirectedRows] = '{
    // empty table: unknown peer, drop, rule with no peer
    '{pamc_pkg::OP_CHECK_IN,  32'h0A00_0001, 6'd0,  8'd0,   1'b1, 1'b0, 8'd0},
    '{pamc_pkg::OP_ROUTE_OUT, 32'hFFFF_FFFF, 6'd0,  8'd0,   1'b1, 1'b0, 8'd0},
    '{pamc_pkg::OP_ADD_RULE,  32'h0A00_0000, 6'd8,  8'd0,   1'b1, 1'b0, 8'd0},
    // peer 0 owns 10/8, host bits of the rule address are cleared
    '{pamc_pkg::OP_NEW_PEER,  32'h0000_0000, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ADD_RULE,  32'h0A12_3456, 6'd8,  8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ROUTE_OUT, 32'h0A00_0000, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    // peer 1 owns the narrower 10.1/16, first match still picks peer 0
    '{pamc_pkg::OP_NEW_PEER,  32'h0000_0000, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ADD_RULE,  32'h0A01_0000, 6'd16, 8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ROUTE_OUT, 32'h0A01_0203, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_CHECK_IN,  32'h0A01_0203, 6'd0,  8'd1,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_CHECK_IN,  32'h0A02_0000, 6'd0,  8'd1,   1'b1, 1'b0, 8'd0},
    // prefix length above 32 stores a host rule
    '{pamc_pkg::OP_ADD_RULE,  32'hFFFF_FFFF, 6'd63, 8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ROUTE_OUT, 32'hFFFF_FFFF, 6'd0,  8'd0,   1'b1, 1'b1, 8'd1},
    '{pamc_pkg::OP_ROUTE_OUT, 32'hFFFF_FFFE, 6'd0,  8'd0,   1'b1, 1'b0, 8'd0},
    '{pamc_pkg::OP_CHECK_IN,  32'hFFFF_FFFF, 6'd0,  8'd255, 1'b1, 1'b0, 8'd0},
    '{pamc_pkg::OP_CHECK_IN,  32'hFFFF_FFFF, 6'd0,  8'd2,   1'b1, 1'b0, 8'd0},
    // peer 2 holds the default route
    '{pamc_pkg::OP_NEW_PEER,  32'h0000_0000, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ADD_RULE,  32'hDEAD_BEEF, 6'd0,  8'd0,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_ROUTE_OUT, 32'hC0A8_0001, 6'd0,  8'd0,   1'b1, 1'b1, 8'd2},
    '{pamc_pkg::OP_CHECK_IN,  32'h0A00_0001, 6'd0,  8'd2,   1'b1, 1'b1, 8'd0},
    '{pamc_pkg::OP_CHECK_IN,  32'h0A00_0001, 6'd0,  8'd1,   1'b1, 1'b0, 8'd0},
    '{pamc_pkg::OP_ADD_RULE,  32'h8000_0000, 6'd1,  8'd0,   1'b0, 1'b0, 8'd0},
    '{pamc_pkg::OP_ROUTE_OUT, 32'h0A01_0000, 6'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    '{pamc_pkg::OP_CHECK_IN,  32'hFFFF_FFFF, 6'd0,  8'd1,   1'b0, 1'b0, 8'd0},
    '{pamc_pkg::OP_ADD_RULE,  32'hFFFF_0000, 6'd33, 8'd0,   1'b0, 1'b0, 8'd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pamc_req_if req_if ();
  pamc_rsp_if rsp_if ();

  peer_allowed_prefix_match_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // shadow rule table, kept in definition order like the block's
  logic [pamc_pkg::AddrW-1:0]   tbl_net   [pamc_pkg::TotalRules];
  logic [pamc_pkg::PrefixW-1:0] tbl_len   [pamc_pkg::TotalRules];
  logic [pamc_pkg::PeerW-1:0]   tbl_owner [pamc_pkg::TotalRules];
  int unsigned        rule_count;
  int unsigned        peers_open;
  int unsigned        last_peer_rules;

  verdict_t    pending_verdicts [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned route_hits;
  int unsigned route_drops;
  int unsigned checks_allowed;
  int unsigned rejects;

  // sender runs without gaps while set; receiver hold-offs are asked by count
  bit          steady_send;
  int unsigned holds_asked;
  int unsigned holds_served;

  // network mask of a clamped prefix length
  function automatic logic [pamc_pkg::AddrW-1:0] prefix_mask(input int unsigned len);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // an address that falls inside stored rule j, host bits random
  function automatic logic [pamc_pkg::AddrW-1:0] inside_rule(input int unsigned j);
    logic [pamc_pkg::AddrW-1:0] noise;
    noise = $urandom;
    return tbl_net[j] | (noise & ~prefix_mask(tbl_len[j]));
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // apply one item to the shadow table and work out the result it gives
  function automatic verdict_t apply_to_table(input pamc_pkg::op_e op,
                                              input logic [pamc_pkg::AddrW-1:0] addr,
                                              input logic [pamc_pkg::PrefixW-1:0] plen,
                                              input logic [pamc_pkg::PeerW-1:0] peer);
    verdict_t    v;
    int unsigned len;
    int unsigned i;
    v   = '0;
    len = (plen > 6'd32) ? 32 : int'(plen);
    case (op)
      pamc_pkg::OP_NEW_PEER: begin
        if (peers_open < pamc_pkg::MaxPeerCount) begin
          peers_open++;
          last_peer_rules = 0;
          v.accepted = 1'b1;
        end
      end
      pamc_pkg::OP_ADD_RULE: begin
        if (peers_open != 0 && last_peer_rules < pamc_pkg::RulesPerPeer &&
            rule_count < pamc_pkg::TotalRules) begin
          tbl_net[rule_count]   = addr & prefix_mask(len);
          tbl_len[rule_count]   = pamc_pkg::PrefixW'(len);
          tbl_owner[rule_count] = pamc_pkg::PeerW'(peers_open - 1);
          rule_count++;
          last_peer_rules++;
          v.accepted = 1'b1;
        end
      end
      pamc_pkg::OP_ROUTE_OUT: begin
        // first stored rule that covers the address wins
        for (i = 0; i < rule_count; i++) begin
          if ((addr & prefix_mask(tbl_len[i])) == tbl_net[i]) begin
            v.accepted   = 1'b1;
            v.peer_found = tbl_owner[i];
            break;
          end
        end
      end
      default: begin
        if (peer < peers_open) begin
          for (i = 0; i < rule_count; i++) begin
            if (tbl_owner[i] == peer && (addr & prefix_mask(tbl_len[i])) == tbl_net[i]) begin
              v.accepted = 1'b1;
              break;
            end
          end
        end
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch at result %0d: %s got %0h expected %0h",
             $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  // offer one item, wait for the handshake, then queue what it should give
  task automatic offer_item(input pamc_pkg::op_e op, input logic [pamc_pkg::AddrW-1:0] addr,
                            input logic [pamc_pkg::PrefixW-1:0] plen,
                            input logic [pamc_pkg::PeerW-1:0] peer,
                            input logic typed, input verdict_t typed_v);
    int unsigned gap;
    verdict_t    v;
    gap = steady_send ? 0 : idle_cycles();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.address     <= addr;
    req_if.prefix_len  <= plen;
    req_if.peer_number <= peer;
    do @(posedge clk_i); while (!req_if.ready);
    v = apply_to_table(op, addr, plen, peer);
    pending_verdicts.push_back(typed ? typed_v : v);
    items_sent++;
    if (!v.accepted) rejects++;
    if (op == pamc_pkg::OP_ROUTE_OUT && v.accepted) route_hits++;
    if (op == pamc_pkg::OP_ROUTE_OUT && !v.accepted) route_drops++;
    if (op == pamc_pkg::OP_CHECK_IN && v.accepted) checks_allowed++;
  endtask

  // result side: random stalls, quiet stretches, and long hold-offs on request
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned cyc;
    wait_left     = 0;
    cyc           = 0;
    holds_served  = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (holds_served != holds_asked) begin
        holds_served++;
        wait_left = HoldCycles;
      end
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        rsp_if.ready <= 1'b0;
      end else if ((cyc % 512) < 128) begin
        rsp_if.ready <= 1'b1;
      end else begin
        wait_left = idle_cycles();
        rsp_if.ready <= (wait_left == 0);
      end
    end
  end

  // compare every taken result with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing expected, accepted", rsp_if.accepted, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_if.accepted !== want.accepted)
          report_mismatch("accepted", rsp_if.accepted, want.accepted);
        if (rsp_if.peer_found !== want.peer_found)
          report_mismatch("peer_found", rsp_if.peer_found, want.peer_found);
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int unsigned                  n;
    int unsigned                  r;
    int unsigned                  j;
    int unsigned                  drain;
    pamc_pkg::op_e                op;
    logic [pamc_pkg::AddrW-1:0]   a;
    logic [pamc_pkg::PrefixW-1:0] pl;
    logic [pamc_pkg::PeerW-1:0]   pn;
    plan_row_t                    row;
    verdict_t                     refused;

    refused            = '0;
    rule_count         = 0;
    peers_open         = 0;
    last_peer_rules    = 0;
    mismatches         = 0;
    items_sent         = 0;
    results_seen       = 0;
    route_hits         = 0;
    route_drops        = 0;
    checks_allowed     = 0;
    rejects            = 0;
    holds_asked        = 0;
    steady_send        = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = pamc_pkg::OP_NEW_PEER;
    req_if.address     = '0;
    req_if.prefix_len  = '0;
    req_if.peer_number = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    for (n = 0; n < DirectedRows; n++) begin
      row = DirectedPlan[n];
      offer_item(row.op, row.addr, row.plen, row.peer, row.typed,
                 '{accepted: row.want_ok, peer_found: row.want_peer});
    end

    // random traffic, mostly lookups aimed at stored prefixes
    for (n = 0; n < RandomItems; n++) begin
      // the sender keeps pushing early in every 64 items and in two windows where the receiver holds off
      steady_send = ((n % 64) < 12) || (n >= 40 && n < 80) || (n >= 120 && n < 160);
      if (n == 40 || n == 120) holds_asked++;
      r  = $urandom_range(0, 99);
      a  = $urandom;
      pl = pamc_pkg::PrefixW'($urandom_range(0, 32));
      pn = pamc_pkg::PeerW'($urandom);
      if (r < 8) begin
        op = pamc_pkg::OP_NEW_PEER;
      end else if (r < 45) begin
        op = pamc_pkg::OP_ADD_RULE;
        // often a rule nested inside one that already exists
        if (rule_count != 0 && $urandom_range(0, 1) == 1) begin
          j  = $urandom_range(0, rule_count - 1);
          a  = inside_rule(j);
          pl = tbl_len[j] + pamc_pkg::PrefixW'($urandom_range(0, 8));
        end
        if ($urandom_range(0, 9) == 0) pl = pamc_pkg::PrefixW'($urandom_range(33, 63));
      end else if (r < 75) begin
        op = pamc_pkg::OP_ROUTE_OUT;
        if (rule_count != 0 && $urandom_range(0, 9) < 7)
          a = inside_rule($urandom_range(0, rule_count - 1));
      end else if (r < 95) begin
        op = pamc_pkg::OP_CHECK_IN;
        if (rule_count != 0 && $urandom_range(0, 9) < 7) begin
          j  = $urandom_range(0, rule_count - 1);
          a  = inside_rule(j);
          pn = tbl_owner[j];
          if ($urandom_range(0, 3) == 0)
            pn = pamc_pkg::PeerW'($urandom_range(0, peers_open - 1));
        end
      end else begin
        // noise: any operation, any field value
        op = pamc_pkg::op_e'($urandom_range(0, 3));
        pl = pamc_pkg::PrefixW'($urandom);
      end
      offer_item(op, a, pl, pn, 1'b0, refused);
    end
    steady_send = 1'b0;

    // open a fresh peer and fill it to the per-peer rule limit
    offer_item(pamc_pkg::OP_NEW_PEER, '0, '0, '0, 1'b0, refused);
    while (last_peer_rules < pamc_pkg::RulesPerPeer && rule_count < pamc_pkg::TotalRules) begin
      offer_item(pamc_pkg::OP_ADD_RULE, $urandom,
                 pamc_pkg::PrefixW'($urandom_range(20, 32)), '0, 1'b0, refused);
    end

    // the full peer refuses any further rule
    offer_item(pamc_pkg::OP_ADD_RULE, $urandom, 6'd0, '0, 1'b1, refused);
    offer_item(pamc_pkg::OP_ADD_RULE, 32'hFFFF_FFFF, 6'd63, '0, 1'b1, refused);

    // lookups that scan the stored rules
    for (n = 0; n < 20; n++) begin
      a  = ($urandom_range(0, 1) == 1) ? inside_rule($urandom_range(0, rule_count - 1))
                                       : 32'($urandom);
      op = (n % 3 == 0) ? pamc_pkg::OP_CHECK_IN : pamc_pkg::OP_ROUTE_OUT;
      pn = (op == pamc_pkg::OP_CHECK_IN) ?
           pamc_pkg::PeerW'($urandom_range(0, peers_open - 1)) : '0;
      offer_item(op, a, '0, pn, 1'b0, refused);
    end

    // open peers up to the peer limit, then go past it
    while (peers_open < pamc_pkg::MaxPeerCount)
      offer_item(pamc_pkg::OP_NEW_PEER, '0, '0, '0, 1'b0, refused);
    offer_item(pamc_pkg::OP_NEW_PEER, $urandom, '0, '0, 1'b1, refused);
    offer_item(pamc_pkg::OP_NEW_PEER, '0, '0, 8'hFF, 1'b1, refused);
    offer_item(pamc_pkg::OP_CHECK_IN, $urandom, '0, 8'd255, 1'b0, refused);
    offer_item(pamc_pkg::OP_ROUTE_OUT, $urandom, '0, '0, 1'b0, refused);
    offer_item(pamc_pkg::OP_ROUTE_OUT, inside_rule(rule_count - 1), '0, '0, 1'b0, refused);

    req_if.valid <= 1'b0;

    // let every expected result come out, then watch for strays
    drain = 0;
    while (pending_verdicts.size() != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    if (pending_verdicts.size() != 0)
      report_mismatch("results never delivered, count", pending_verdicts.size(), 0);
    repeat (pamc_pkg::TotalRules + 4) @(posedge clk_i);

    $display("run covered %0d items and %0d results: %0d peers, %0d rules stored",
             items_sent, results_seen, peers_open, rule_count);
    $display("routes hit %0d, drops %0d, check_in allowed %0d, rejected or empty %0d",
             route_hits, route_drops, checks_allowed, rejects);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin : watchdog
    #(TimeoutNs);
    $display("Verification failed");
    $finish;
  end

endmodule
